[rtl/btpc_pkg.sv]
// Shared types and constants for the beep tone peak counter.
// No dependencies; imported by the top level and its checker.
package btpc_pkg;

  // Default build parameters
  localparam int FFT_LENGTH_DEFAULT  = 256;
  localparam int SAMPLE_RATE_DEFAULT = 33000;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int VOL_W      = 12;
  localparam int TONE_W     = 15;
  localparam int COUNT_W    = 8;
  localparam int PEAK_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int POWER_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register reset values
  localparam logic [VOL_W-1:0]   MIN_VOLUME_RST = VOL_W'(270);
  localparam logic [VOL_W-1:0]   MAX_VOLUME_RST = VOL_W'(1000);
  localparam logic [TONE_W-1:0]  TONE_A_RST     = TONE_W'(10570);
  localparam logic [TONE_W-1:0]  TONE_B_RST     = TONE_W'(8378);
  localparam logic [TONE_W-1:0]  TONE_C_RST     = TONE_W'(15339);
  localparam logic [TONE_W-1:0]  TONE_D_RST     = TONE_W'(10441);
  localparam logic [COUNT_W-1:0] GOAL_COUNT_RST = '0;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VOLUME = 3'd0,
    CFG_MAX_VOLUME = 3'd1,
    CFG_TONE_A     = 3'd2,
    CFG_TONE_B     = 3'd3,
    CFG_TONE_C     = 3'd4,
    CFG_TONE_D     = 3'd5,
    CFG_GOAL_COUNT = 3'd6
  } cfg_reg_t;

endpackage

[rtl/beep_tone_peak_counter.sv]
// Beep tone peak counter: spectrum peak search, tone match and beep counting.
// Depends on btpc_pkg.
//
// Takes one word per cycle when the output is not stalled and returns one result
// word per input word. The word is captured by the input register, then the
// power register, then the result register, which drives the ports. Throughput
// is one word per clock while out_ready drains results; the only feedback path is the running
// peak compare and the count update in the result stage. Bins are power
// searched over the first FFT_LENGTH/2 positions of each window; a word with
// last_bin set closes the window, maps the peak bin to hertz and checks it
// against the four tone registers and the volume band. A word with func set
// ends an oscillator cycle: it reports too_far (count below goal) and clears
// the count. FFT_LENGTH must be a power of two. Configuration writes are
// taken any cycle (cfg_ready is tied high) but are only meant while idle.
module beep_tone_peak_counter
  import btpc_pkg::*;
#(
  parameter int FFT_LENGTH     = FFT_LENGTH_DEFAULT,
  parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic signed [SAMPLE_W-1:0]   bin_real,
  input  logic signed [SAMPLE_W-1:0]   bin_imag,
  input  logic                         last_bin,
  input  logic [VOL_W-1:0]             window_volume,
  // result words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         tone_heard,
  output logic                         beep_counted,
  output logic [COUNT_W-1:0]           beep_total,
  output logic [PEAK_W-1:0]            peak_index,
  output logic                         too_far,
  output logic                         cycle_done
);

  localparam int HALF     = FFT_LENGTH / 2;
  localparam int IDX_W    = $clog2(HALF);
  localparam int POS_W    = IDX_W + 1;
  localparam int LOG2_FFT = $clog2(FFT_LENGTH);
  // bin * rate numerator, tracked by accumulation instead of a multiplier
  localparam int NUM_W    = $clog2(HALF * SAMPLE_RATE_HZ);
  localparam int FREQ_W   = NUM_W - LOG2_FFT;
  localparam int CMP_W    = (FREQ_W > TONE_W) ? FREQ_W : TONE_W;

  localparam logic [POS_W-1:0] POS_HALF  = POS_W'(HALF);
  localparam logic [NUM_W-1:0] RATE_STEP = NUM_W'(SAMPLE_RATE_HZ);

  // ---------------- configuration registers ----------------
  logic [VOL_W-1:0]   min_volume, max_volume;
  logic [TONE_W-1:0]  tone_a, tone_b, tone_c, tone_d;
  logic [COUNT_W-1:0] goal_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_volume <= MIN_VOLUME_RST;
      max_volume <= MAX_VOLUME_RST;
      tone_a     <= TONE_A_RST;
      tone_b     <= TONE_B_RST;
      tone_c     <= TONE_C_RST;
      tone_d     <= TONE_D_RST;
      goal_count <= GOAL_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MIN_VOLUME: min_volume <= cfg_data[VOL_W-1:0];
        CFG_MAX_VOLUME: max_volume <= cfg_data[VOL_W-1:0];
        CFG_TONE_A:     tone_a     <= cfg_data[TONE_W-1:0];
        CFG_TONE_B:     tone_b     <= cfg_data[TONE_W-1:0];
        CFG_TONE_C:     tone_c     <= cfg_data[TONE_W-1:0];
        CFG_TONE_D:     tone_d     <= cfg_data[TONE_W-1:0];
        CFG_GOAL_COUNT: goal_count <= cfg_data[COUNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  // Each stage loads when empty or when its successor loads, so bubbles
  // collapse and input is still taken while a result waits, until the stages fill.
  logic s1_valid, s2_valid;
  logic out_load, s2_ready, s1_ready, fire;

  assign out_load = !out_valid || out_ready;
  assign s2_ready = !s2_valid || out_load;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign fire     = s2_valid && out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (out_load) out_valid <= s2_valid;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic                       s1_func, s1_last;
  logic signed [SAMPLE_W-1:0] s1_real, s1_imag;
  logic [VOL_W-1:0]           s1_volume;

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_func   <= func;
      s1_real   <= bin_real;
      s1_imag   <= bin_imag;
      s1_last   <= last_bin;
      s1_volume <= window_volume;
    end
  end

  // ---------------- stage 2: bin power ----------------
  // |x| fits 16 bits unsigned (32768 included); sum of squares fits 32 bits
  logic [SAMPLE_W-1:0] mag_re, mag_im;
  logic [POWER_W-1:0]  power;

  assign mag_re = s1_real[SAMPLE_W-1] ? SAMPLE_W'(-s1_real) : SAMPLE_W'(s1_real);
  assign mag_im = s1_imag[SAMPLE_W-1] ? SAMPLE_W'(-s1_imag) : SAMPLE_W'(s1_imag);
  assign power  = POWER_W'(mag_re * mag_re) + POWER_W'(mag_im * mag_im);

  logic               s2_func, s2_last;
  logic [POWER_W-1:0] s2_power;
  logic [VOL_W-1:0]   s2_volume;

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_func   <= s1_func;
      s2_last   <= s1_last;
      s2_power  <= power;
      s2_volume <= s1_volume;
    end
  end

  // ---------------- stage 3: peak tracking, tone match, count ----------------
  logic [POS_W-1:0]   bin_position, bin_position_next;
  logic [NUM_W-1:0]   bin_numer, bin_numer_next;     // bin_position * rate
  logic [POWER_W-1:0] best_power, best_power_next;
  logic [IDX_W-1:0]   best_index, best_index_next;
  logic [NUM_W-1:0]   best_numer, best_numer_next;   // best_index * rate
  logic               heard_before, heard_before_next;
  logic               heard_two_before, heard_two_before_next;
  logic [COUNT_W-1:0] beep_count, beep_count_next;
  logic               far_mode, far_mode_next;

  logic               in_window, take, hit, count_new;
  logic [IDX_W-1:0]   idx_upd;
  logic [NUM_W-1:0]   numer_upd;
  logic [FREQ_W-1:0]  freq;
  logic [CMP_W-1:0]   freq_cmp;
  logic               vol_ok, tone_match;

  assign in_window = bin_position < POS_HALF;
  // first bin of a window always seeds the search; ties keep the earlier bin
  assign take      = in_window && (bin_position == '0 || s2_power > best_power);
  assign idx_upd   = take ? bin_position[IDX_W-1:0] : best_index;
  assign numer_upd = take ? bin_numer : best_numer;

  // hertz = bin * rate / FFT_LENGTH, rounded down
  assign freq       = numer_upd[NUM_W-1:LOG2_FFT];
  assign freq_cmp   = CMP_W'(freq);
  assign tone_match = freq_cmp == CMP_W'(tone_a) || freq_cmp == CMP_W'(tone_b) ||
                      freq_cmp == CMP_W'(tone_c) || freq_cmp == CMP_W'(tone_d);
  assign vol_ok     = s2_volume > min_volume && s2_volume < max_volume;
  assign hit        = vol_ok && tone_match;
  // count only a tone after two silent windows
  assign count_new  = hit && !heard_before && !heard_two_before;

  always_comb begin
    bin_position_next     = bin_position;
    bin_numer_next        = bin_numer;
    best_power_next       = best_power;
    best_index_next       = best_index;
    best_numer_next       = best_numer;
    heard_before_next     = heard_before;
    heard_two_before_next = heard_two_before;
    beep_count_next       = beep_count;
    far_mode_next         = far_mode;
    if (fire) begin
      if (s2_func) begin
        // cycle end: judge and clear; a window in progress is left alone
        far_mode_next   = beep_count < goal_count;
        beep_count_next = '0;
      end else begin
        if (in_window) begin
          if (take) best_power_next = s2_power;
          best_index_next   = idx_upd;
          best_numer_next   = numer_upd;
          bin_position_next = bin_position + POS_W'(1);
          bin_numer_next    = bin_numer + RATE_STEP;
        end
        if (s2_last) begin
          if (count_new && beep_count != COUNT_MAX) beep_count_next = beep_count + COUNT_W'(1);
          heard_two_before_next = heard_before;
          heard_before_next     = hit;
          bin_position_next     = '0;
          bin_numer_next        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_position     <= '0;
      bin_numer        <= '0;
      best_power       <= '0;
      best_index       <= '0;
      best_numer       <= '0;
      heard_before     <= 1'b0;
      heard_two_before <= 1'b0;
      beep_count       <= '0;
      far_mode         <= 1'b0;
    end else begin
      bin_position     <= bin_position_next;
      bin_numer        <= bin_numer_next;
      best_power       <= best_power_next;
      best_index       <= best_index_next;
      best_numer       <= best_numer_next;
      heard_before     <= heard_before_next;
      heard_two_before <= heard_two_before_next;
      beep_count       <= beep_count_next;
      far_mode         <= far_mode_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (fire) begin
      tone_heard   <= !s2_func && s2_last && hit;
      beep_counted <= !s2_func && s2_last && count_new;
      // cycle end reports the count before it is cleared
      beep_total   <= s2_func ? beep_count : beep_count_next;
      peak_index   <= PEAK_W'(best_index_next);
      too_far      <= far_mode_next;
      cycle_done   <= s2_func;
    end
  end

endmodule

[rtl/btpc_checker.sv]
// Port-level assertions for the beep tone peak counter, bound to the top level.
// Depends on btpc_pkg.
module btpc_checker
  import btpc_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       tone_heard,
  input logic                       beep_counted,
  input logic [COUNT_W-1:0]         beep_total,
  input logic [PEAK_W-1:0]          peak_index,
  input logic                       too_far,
  input logic                       cycle_done
);

  // a cycle-end word never reports a tone or a count
  a_cycle_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && cycle_done |-> !tone_heard && !beep_counted)
    else $error("cycle-end word carries a tone or count");

  // a counted beep is always a heard tone, and the total includes it
  a_count_tone: assert property (@(posedge clk) disable iff (rst)
    out_valid && beep_counted |-> tone_heard && beep_total != '0)
    else $error("counted beep without tone or with zero total");

  // two counted windows in back-to-back results are impossible
  a_count_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && beep_counted ##1 out_valid |-> !beep_counted)
    else $error("beep counted in two adjacent windows");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(beep_total) &&
      $stable(peak_index) && $stable(cycle_done) && $stable(too_far))
    else $error("result changed while stalled");

endmodule

bind beep_tone_peak_counter btpc_checker u_btpc_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 100ps
// Testbench for beep_tone_peak_counter: a directed table, then random windows, scored
// against typed-in results or an in-bench peak / tone / beep predictor.
// Depends on btpc_pkg and rtl/beep_tone_peak_counter.sv.
module testbench;
  import btpc_pkg::*;

  localparam int HALF_BINS   = FFT_LENGTH_DEFAULT / 2;
  localparam int LATENCY     = 3;     // input reg, power stage, result reg
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int SAT_ROUNDS  = 258;   // enough counted beeps to pin the count at max

  // one input word and one result word, laid out as the ports
  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       last;
    logic [VOL_W-1:0]           vol;
  } word_t;

  typedef struct packed {
    logic               tone;
    logic               counted;
    logic [COUNT_W-1:0] total;
    logic [PEAK_W-1:0]  peak;
    logic               far;
    logic               done;
  } verdict_t;

  localparam int WORD_W = $bits(word_t);

  typedef enum bit {STEP_WORD, STEP_CFG} step_kind_t;

  // directed step: either a word (with an optional typed-in result) or a register write
  typedef struct packed {
    step_kind_t              kind;
    cfg_reg_t                cfg_sel;
    logic [CFG_DATA_W-1:0]   data;
    word_t                   w;
    bit                      typed;
    verdict_t                r;
  } step_t;

  localparam word_t    NO_WORD    = '0;
  localparam verdict_t NO_VERDICT = '0;

  // ---------------------------------------------------------------------------
  // DUT signals; every driven input starts at a known value
  // ---------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       func = 1'b0;
  logic signed [SAMPLE_W-1:0] bin_real = '0;
  logic signed [SAMPLE_W-1:0] bin_imag = '0;
  logic                       last_bin = 1'b0;
  logic [VOL_W-1:0]           window_volume = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       tone_heard;
  logic                       beep_counted;
  logic [COUNT_W-1:0]         beep_total;
  logic [PEAK_W-1:0]          peak_index;
  logic                       too_far;
  logic                       cycle_done;

  beep_tone_peak_counter dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: registers and window tracking, at their reset values
  // ---------------------------------------------------------------------------
  int unsigned       vol_lo = MIN_VOLUME_RST;
  int unsigned       vol_hi = MAX_VOLUME_RST;
  int unsigned       tone_hz [4] = '{TONE_A_RST, TONE_B_RST, TONE_C_RST, TONE_D_RST};
  int unsigned       goal = GOAL_COUNT_RST;
  int                bin_pos = 0;
  logic [POWER_W-1:0] best_pw = '0;
  int                best_bin = 0;
  bit                heard_1 = 1'b0;  // previous window had a tone
  bit                heard_2 = 1'b0;  // the one before that
  int unsigned       beeps = 0;
  bit                far = 1'b0;

  verdict_t due_verdicts [$];  // results still owed by the block, oldest first
  bit       failed = 1'b0;
  bit       hold_req = 1'b0;    // asks the receiver for its long hold-off
  int       burst_left = 0;
  int       phase_sent = 0;
  int       quiet = 0;

  function automatic int unsigned bin_hz(input int b);
    return b * SAMPLE_RATE_DEFAULT / FFT_LENGTH_DEFAULT;
  endfunction

  // Advance the predictor by one accepted word and return the result it owes.
  function automatic verdict_t predict_verdict(input word_t w);
    verdict_t           v;
    int                 re;
    int                 im;
    logic [POWER_W-1:0] pw;
    bit                 hit;
    v = NO_VERDICT;
    if (w.func) begin
      // cycle end: judge the count, report it, clear it; window in flight untouched
      far = beeps < goal;
      v.total = COUNT_W'(beeps);
      beeps = 0;
      v.done = 1'b1;
    end else begin
      if (bin_pos < HALF_BINS) begin
        re = $signed(w.re);
        im = $signed(w.im);
        pw = POWER_W'(re * re) + POWER_W'(im * im);
        // first bin always seeds the search; ties keep the earlier bin
        if (bin_pos == 0 || pw > best_pw) begin
          best_pw = pw;
          best_bin = bin_pos;
        end
        bin_pos++;
      end
      if (w.last) begin
        hit = 1'b0;
        foreach (tone_hz[k]) if (bin_hz(best_bin) == tone_hz[k]) hit = 1'b1;
        hit = hit && w.vol > vol_lo && w.vol < vol_hi;
        v.tone = hit;
        v.counted = hit && !heard_1 && !heard_2;
        if (v.counted && beeps < COUNT_MAX) beeps++;
        heard_2 = heard_1;
        heard_1 = hit;
        bin_pos = 0;
      end
      v.total = COUNT_W'(beeps);
    end
    v.peak = PEAK_W'(best_bin);
    v.far = far;
    return v;
  endfunction

  function automatic word_t rand_word();
    return WORD_W'({$urandom, $urandom});
  endfunction

  // Mostly inside the band, sometimes right on an edge, sometimes anywhere.
  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 9))
      0: return VOL_W'(vol_lo);
      1: return VOL_W'(vol_hi);
      2, 3: return VOL_W'($urandom);
      default: begin
        if (vol_hi > vol_lo + 1) return VOL_W'($urandom_range(vol_lo + 1, vol_hi - 1));
        return VOL_W'($urandom);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. The word is
  // scored at the edge it is taken.
  // ---------------------------------------------------------------------------
  task automatic send_word(input word_t w, input bit typed, input verdict_t typed_v);
    int       gap;
    verdict_t v;
    if (burst_left == 0 && !hold_req) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    func <= w.func;
    bin_real <= w.re;
    bin_imag <= w.im;
    last_bin <= w.last;
    window_volume <= w.vol;
    do @(posedge clk); while (!in_ready);
    v = predict_verdict(w);
    due_verdicts.push_back(typed ? typed_v : v);
  endtask

  // Drop valid, let every owed result come back, then give the pipe a moment.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  // cfg_valid is left high so back-to-back writes run without a gap; callers drop it
  task automatic set_reg(input cfg_reg_t sel, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      CFG_MIN_VOLUME: vol_lo = val;
      CFG_MAX_VOLUME: vol_hi = val;
      CFG_TONE_A:     tone_hz[0] = val;
      CFG_TONE_B:     tone_hz[1] = val;
      CFG_TONE_C:     tone_hz[2] = val;
      CFG_TONE_D:     tone_hz[3] = val;
      CFG_GOAL_COUNT: goal = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned vals [7]);
    settle();
    for (int i = 0; i < 7; i++) set_reg(cfg_reg_t'(i), vals[i]);
    cfg_valid <= 1'b0;
  endtask

  // One window of len bins. peak_at < 0 gives pure noise; otherwise one strong
  // bin at peak_at over weak ones, with the odd exact copy later on (a tie).
  // Now and then a cycle end lands in the middle of the window.
  task automatic emit_window(input int len, input int peak_at);
    word_t w;
    word_t peak_word;
    int    mag;
    peak_word = rand_word();
    mag = $urandom_range(20000, 32768);
    peak_word.re = SAMPLE_W'($urandom_range(0, 1) ? -mag : mag);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        w = rand_word();
        w.func = 1'b1;
        send_word(w, 1'b0, NO_VERDICT);
      end
      w = rand_word();
      w.func = 1'b0;
      if (i == peak_at || (peak_at >= 0 && i > peak_at && $urandom_range(0, 19) == 0)) begin
        w.re = peak_word.re;
        w.im = peak_word.im;
      end else if (peak_at >= 0) begin
        w.re = SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
        w.im = SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
      end
      w.last = (i == len - 1);
      if (w.last) w.vol = pick_volume();
      send_word(w, 1'b0, NO_VERDICT);
      phase_sent++;
    end
    if ($urandom_range(0, 5) == 0) begin
      w = rand_word();
      w.func = 1'b1;
      send_word(w, 1'b0, NO_VERDICT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Typed-in results are only the ones obvious by hand; the
  // rest fall back to the predictor.
  // ---------------------------------------------------------------------------
  localparam int PLAN_LEN = 24;
  step_t plan [PLAN_LEN] = '{
    // cycle end straight out of reset: count 0 against goal 0
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b1, 16'h0000, 16'h0000, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 1'b0, 1'b1}},
    // one-bin all-zero window: peak is bin 0, 0 Hz matches no default tone
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h0000, 16'h0000, 1'b1, 12'd500},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 1'b0, 1'b0}},
    // extremes: most negative pair is the largest power, later equal one loses
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h0000, 16'h0000, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 1'b0, 1'b0}},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h8000, 16'h8000, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd1, 1'b0, 1'b0}},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h7FFF, 16'h8000, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd1, 1'b0, 1'b0}},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h8000, 16'h8000, 1'b1, 12'd4095},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd1, 1'b0, 1'b0}},
    // equal powers 3,4 and -5,0: first bin wins
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h0003, 16'h0004, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 1'b0, 1'b0}},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'hFFFB, 16'h0000, 1'b1, 12'd500},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 1'b0, 1'b0}},
    // make bin 0 a tone and open the band all the way
    '{STEP_CFG, CFG_TONE_A, 15'd0, NO_WORD, 1'b0, NO_VERDICT},
    '{STEP_CFG, CFG_MIN_VOLUME, 15'd0, NO_WORD, 1'b0, NO_VERDICT},
    '{STEP_CFG, CFG_MAX_VOLUME, 15'd4095, NO_WORD, 1'b0, NO_VERDICT},
    // tone after quiet windows counts; the next one right after does not
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h1234, 16'h8000, 1'b1, 12'd1},
      1'b1, '{1'b1, 1'b1, 8'd1, 7'd0, 1'b0, 1'b0}},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h7FFF, 16'h7FFF, 1'b1, 12'd4094},
      1'b1, '{1'b1, 1'b0, 8'd1, 7'd0, 1'b0, 1'b0}},
    // volume on either band edge is outside
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h0000, 16'h0000, 1'b1, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd1, 7'd0, 1'b0, 1'b0}},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h0000, 16'h0000, 1'b1, 12'd4095},
      1'b1, '{1'b0, 1'b0, 8'd1, 7'd0, 1'b0, 1'b0}},
    // two quiet windows behind it: counted again
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h0000, 16'h0001, 1'b1, 12'd2048},
      1'b1, '{1'b1, 1'b1, 8'd2, 7'd0, 1'b0, 1'b0}},
    // goal at max: short of it, then cleared count still short
    '{STEP_CFG, CFG_GOAL_COUNT, 15'd255, NO_WORD, 1'b0, NO_VERDICT},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b1, 16'h0000, 16'h0000, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd2, 7'd0, 1'b1, 1'b1}},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b1, 16'h0000, 16'h0000, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 1'b1, 1'b1}},
    '{STEP_CFG, CFG_GOAL_COUNT, 15'd0, NO_WORD, 1'b0, NO_VERDICT},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b1, 16'h0000, 16'h0000, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 8'd0, 7'd0, 1'b0, 1'b1}},
    // cycle end in the middle of a window, junk on the ignored fields
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h0000, 16'h0005, 1'b0, 12'd0},
      1'b0, NO_VERDICT},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b1, 16'h7FFF, 16'h8000, 1'b1, 12'd4095},
      1'b0, NO_VERDICT},
    '{STEP_WORD, CFG_MIN_VOLUME, 15'd0, '{1'b0, 16'h0000, 16'h0009, 1'b1, 12'd2000},
      1'b0, NO_VERDICT}
  };

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random phases under several settings
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned regs [7];
    int          budget;
    int          len;
    int          peak_at;
    word_t       w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == STEP_CFG) begin
        if (i == 0 || plan[i - 1].kind != STEP_CFG) settle();
        set_reg(plan[i].cfg_sel, plan[i].data);
        if (i == PLAN_LEN - 1 || plan[i + 1].kind != STEP_CFG) cfg_valid <= 1'b0;
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].r);
      end
    end

    // phase 0: reset settings but a random goal, long windows peaking on the default tone bins
    // phases 1-3: tones moved to low bins so short windows can hit them
    // phase 4: empty band, tones at their extremes, goal at max
    // phase 5: count driven into saturation
    // phase 6: everything random
    for (int ph = 0; ph < 7; ph++) begin
      budget = 170;
      case (ph)
        0: begin
          regs = '{MIN_VOLUME_RST, MAX_VOLUME_RST, TONE_A_RST, TONE_B_RST, TONE_C_RST,
                   TONE_D_RST, $urandom_range(0, 3)};
          budget = 250;
        end
        1, 2, 3: begin
          regs[0] = $urandom_range(0, 300);
          regs[1] = $urandom_range(600, 4095);
          for (int k = 2; k < 6; k++) regs[k] = bin_hz($urandom_range(0, 12));
          regs[6] = $urandom_range(0, 6);
        end
        4: begin
          regs = '{4095, 0, 16500, 0, 16500, 0, 255};
          budget = 80;
        end
        5: regs = '{0, 4095, bin_hz(0), 16500, 16500, 16500, 255};
        default: begin
          regs[0] = $urandom_range(0, 4095);
          regs[1] = $urandom_range(0, 4095);
          for (int k = 2; k < 6; k++)
            regs[k] = $urandom_range(0, 1) ? bin_hz($urandom_range(0, 20)) : $urandom_range(0, 16500);
          regs[6] = $urandom_range(0, 255);
          budget = 150;
        end
      endcase
      apply_settings(regs);

      // receiver goes dark while the sender keeps pushing: pipe fills, in_ready drops
      if (ph == 2) hold_req = 1'b1;

      if (ph == 5) begin
        // hit, quiet, quiet: every third window is counted
        for (int n = 0; n < SAT_ROUNDS; n++) begin
          for (int k = 0; k < 3; k++) begin
            w = rand_word();
            w.func = 1'b0;
            w.last = 1'b1;
            w.vol = (k == 0) ? VOL_W'($urandom_range(1, 4094)) : ((k == 1) ? '0 : '1);
            send_word(w, 1'b0, NO_VERDICT);
          end
        end
        w = rand_word();
        w.func = 1'b1;
        send_word(w, 1'b0, NO_VERDICT);
      end else begin
        phase_sent = 0;
        while (phase_sent < budget) begin
          if (ph == 0) begin
            case ($urandom_range(0, 4))
              0: peak_at = 82;
              1: peak_at = 65;
              2: peak_at = 119;
              3: peak_at = 81;
              default: peak_at = -1;
            endcase
            // some windows run past the half window
            len = $urandom_range(84, 140);
            if (len <= peak_at) len = peak_at + 1 + $urandom_range(0, 8);
          end else begin
            len = $urandom_range(1, 16);
            peak_at = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, len - 1);
          end
          emit_window(len, peak_at);
        end
      end
    end

    settle();
    if (!failed && due_verdicts.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches among four stall patterns of its own, plus the one long
  // hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        cyc++;
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= (cyc % 4) != 3;
          2: out_ready <= $urandom_range(0, 1);
          default: out_ready <= (cyc % 5) == 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: each result word against the oldest owed one, field by field
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      failed = 1'b1;
    end
  endtask

  verdict_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_verdicts.size() == 0) begin
        $display("%0t: result word with nothing owed", $time);
        failed = 1'b1;
      end else begin
        want = due_verdicts.pop_front();
        check_field("tone_heard", want.tone, tone_heard);
        check_field("beep_counted", want.counted, beep_counted);
        check_field("beep_total", want.total, beep_total);
        check_field("peak_index", want.peak, peak_index);
        check_field("too_far", want.far, too_far);
        check_field("cycle_done", want.done, cycle_done);
      end
    end
  end

  // Watchdog: any handshake resets the quiet count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
